// ===== design/tsil_pkg.sv =====
// Package for the timestamp sorted insert list: sizes, mode codes, word types.
// Used by tsil_cell and timestamp_sorted_insert_list; depends on nothing else.
package tsil_pkg;

   localparam int CAPACITY    = 16;
   localparam int STAMP_BITS  = 32;
   localparam int HANDLE_BITS = 16;
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      MODE_INSERT  = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_NEXT    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [STAMP_BITS-1:0]  stamp;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   // What one cell hands to its right-hand neighbor
   typedef struct packed {
      logic      ins;
      entry_type entry;
   } link_type;

   typedef struct packed {
      mode_type               mode;
      logic [STAMP_BITS-1:0]  stamp;
      logic [HANDLE_BITS-1:0] message_handle;
   } req_type;

   typedef struct packed {
      logic                   item_valid;
      logic [STAMP_BITS-1:0]  out_stamp;
      logic [HANDLE_BITS-1:0] out_handle;
      logic                   scan_done;
      logic                   insert_refused;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_type;

endpackage

// ===== design/timestamp_sorted_insert_list.sv =====
// Top level of the timestamp sorted insert list: a row of tsil_cell slots,
// fill count, scan cursor and the registered result word. Depends on tsil_pkg.
//
//   channel   ports                  handshake
//   -------   --------------------   ------------------------------------
//   request   start, busy, req       word taken when start && !busy
//   result    rsp_strobe, rsp        word valid for one cycle, no backpressure
//
// Every request word is taken when offered; busy stays low, so a word may
// follow in every cycle. An insert compares the new stamp in all cells at once
// and shifts the tail right by one slot in that same cycle.
// The result word appears on the cycle after the request is taken.
// Synchronous reset empties the list and parks the cursor at the front;
// slot contents are not cleared, empty slots are never read.
module timestamp_sorted_insert_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tsil_pkg::req_type req,
   output logic              rsp_strobe,
   output tsil_pkg::rsp_type rsp
);
   import tsil_pkg::*;

   localparam int IDX_BITS = $clog2(CAPACITY);

   logic                  accept;
   logic [COUNT_BITS-1:0] fill_ff, fill_in;
   logic [COUNT_BITS-1:0] cursor_ff, cursor_in;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  full;
   logic                  insert_en;
   logic                  has_item;
   logic [CAPACITY-1:0]   occupied;
   entry_type             new_entry;
   entry_type             read_entry;
   link_type              links [CAPACITY];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign full      = (fill_ff == COUNT_BITS'(CAPACITY));
   assign insert_en = accept && (req.mode == MODE_INSERT) && !full;
   assign has_item  = (cursor_ff < fill_ff);

   assign new_entry.stamp  = req.stamp;
   assign new_entry.handle = req.message_handle;

   // Build the chain of slots; the leftmost slot sees no insert from the left
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         link_type prev_link;
         assign occupied[gi] = (COUNT_BITS'(gi) < fill_ff);
         if (gi == 0) begin : g_head
            assign prev_link = '0;
         end else begin : g_body
            assign prev_link = links[gi-1];
         end
         tsil_cell u_cell (
            .clock     (clock),
            .insert_en (insert_en),
            .occupied  (occupied[gi]),
            .new_entry (new_entry),
            .prev_link (prev_link),
            .link      (links[gi])
         );
      end
   endgenerate

   // Select the slot under the cursor
   assign read_entry = links[cursor_ff[IDX_BITS-1:0]].entry;

   // Next fill count and cursor
   always_comb begin
      fill_in   = fill_ff;
      cursor_in = cursor_ff;
      if (accept) begin
         case (req.mode)
            MODE_INSERT: begin
               cursor_in = '0;
               if (!full) begin
                  fill_in = fill_ff + COUNT_BITS'(1);
               end
            end
            MODE_RESTART: begin
               cursor_in = '0;
            end
            MODE_NEXT: begin
               if (has_item) begin
                  cursor_in = cursor_ff + COUNT_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Assemble the result word from the post-step status
   always_comb begin
      rsp_in                = '0;
      rsp_in.scan_done      = (cursor_in >= fill_in);
      rsp_in.entry_count    = fill_in;
      case (req.mode)
         MODE_INSERT: begin
            rsp_in.insert_refused = full;
         end
         MODE_NEXT: begin
            if (has_item) begin
               rsp_in.item_valid = 1'b1;
               rsp_in.out_stamp  = read_entry.stamp;
               rsp_in.out_handle = read_entry.handle;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         cursor_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         cursor_ff     <= cursor_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   // Fill count never exceeds the number of slots
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_BITS'(CAPACITY))
      else $error("fill count above capacity");

   // Cursor never runs past the fill count
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= fill_ff)
      else $error("scan cursor past fill count");

   // An accepted insert parks the cursor at the front
   a_insert_cursor: assert property (@(posedge clock) disable iff (reset)
      accept && (req.mode == MODE_INSERT) |=> cursor_ff == '0)
      else $error("cursor not at front after insert");

   // A refused insert only happens on a full list and leaves it full
   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.insert_refused |-> rsp.entry_count == COUNT_BITS'(CAPACITY))
      else $error("insert refused on a list that is not full");

   // A returned item advances the cursor
   a_read_advance: assert property (@(posedge clock) disable iff (reset)
      accept && (req.mode == MODE_NEXT) && has_item |=> cursor_ff == $past(cursor_ff) + 1'b1)
      else $error("cursor did not advance on read");

endmodule

// ===== design/tsil_cell.sv =====
// One slot of the sorted list: holds a stamp/handle pair and shifts right on insert.
// Depends on tsil_pkg.
module tsil_cell (
   input  logic               clock,
   input  logic               insert_en,
   input  logic               occupied,
   input  tsil_pkg::entry_type new_entry,
   input  tsil_pkg::link_type  prev_link,
   output tsil_pkg::link_type  link
);
   import tsil_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      ins_here;

   // New word goes at or before this slot when the slot is empty or not earlier
   assign ins_here = !occupied || (new_entry.stamp <= entry_ff.stamp);

   // Take the neighbor's word when the insert point lies to the left,
   // take the new word when the insert point is here, else hold
   always_comb begin
      entry_in = entry_ff;
      if (insert_en) begin
         if (prev_link.ins) begin
            entry_in = prev_link.entry;
         end else if (ins_here) begin
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.ins   = ins_here || prev_link.ins;
   assign link.entry = entry_ff;

endmodule

// ===== bench/timestamp_sorted_insert_list_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timestamp_sorted_insert_list: directed table then random words,
// every result word checked against the table's typed word or an in-bench model of the sorted list.
// Depends on tsil_pkg and the timestamp_sorted_insert_list RTL.
module timestamp_sorted_insert_list_test;
   import tsil_pkg::*;

   localparam int       WORD_TARGET = 1400;
   localparam int       NUM_ROWS    = 15;
   localparam mode_type MODE_UNUSED = mode_type'(2'd3);

   // One directed row: the request word and, where typed, its result word
   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;

   // Model of the list contents, fill count and scan cursor
   logic [STAMP_BITS-1:0]  model_stamp  [CAPACITY];
   logic [HANDLE_BITS-1:0] model_handle [CAPACITY];
   int                     model_fill;
   int                     model_cursor;

   rsp_type pending_words [$];
   int      error_count;

   const plan_row_type plan [NUM_ROWS] = '{
      // empty list: next, unused mode and restart report status only
      '{'{MODE_NEXT, 32'h0, 16'h0}, 1'b1, '{1'b0, 32'h0, 16'h0, 1'b1, 1'b0, 5'd0}},
      '{'{MODE_UNUSED, 32'hffff_ffff, 16'hffff}, 1'b1,
        '{1'b0, 32'h0, 16'h0, 1'b1, 1'b0, 5'd0}},
      '{'{MODE_RESTART, 32'h0, 16'h0}, 1'b1, '{1'b0, 32'h0, 16'h0, 1'b1, 1'b0, 5'd0}},
      // extreme stamps and handles
      '{'{MODE_INSERT, 32'hffff_ffff, 16'hffff}, 1'b1,
        '{1'b0, 32'h0, 16'h0, 1'b0, 1'b0, 5'd1}},
      '{'{MODE_INSERT, 32'h0, 16'h0}, 1'b1, '{1'b0, 32'h0, 16'h0, 1'b0, 1'b0, 5'd2}},
      // ties in the middle and at the front go ahead of older entries
      '{'{MODE_INSERT, 32'h8000_0000, 16'h1234}, 1'b0, '{default: '0}},
      '{'{MODE_INSERT, 32'h8000_0000, 16'h5678}, 1'b0, '{default: '0}},
      '{'{MODE_INSERT, 32'h0, 16'h0001}, 1'b0, '{default: '0}},
      '{'{MODE_NEXT, 32'h0, 16'h0}, 1'b0, '{default: '0}},
      '{'{MODE_NEXT, 32'h0, 16'h0}, 1'b0, '{default: '0}},
      '{'{MODE_RESTART, 32'hffff_ffff, 16'hffff}, 1'b0, '{default: '0}},
      '{'{MODE_NEXT, 32'hffff_ffff, 16'hffff}, 1'b0, '{default: '0}},
      // insert pulls the cursor back to the front
      '{'{MODE_INSERT, 32'h7fff_ffff, 16'h0}, 1'b0, '{default: '0}},
      '{'{MODE_NEXT, 32'h0, 16'h0}, 1'b0, '{default: '0}},
      '{'{MODE_UNUSED, 32'ha5a5_a5a5, 16'h5a5a}, 1'b0, '{default: '0}}
   };

   timestamp_sorted_insert_list u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one word to the list model and return the result word it gives
   function automatic rsp_type list_step(input req_type word);
      rsp_type result;
      int      pos;
      result = '0;
      case (word.mode)
         MODE_INSERT: begin
            model_cursor = 0;
            if (model_fill >= CAPACITY) begin
               result.insert_refused = 1'b1;
            end else begin
               pos = 0;
               while (pos < model_fill && model_stamp[pos] < word.stamp) pos++;
               for (int i = model_fill; i > pos; i--) begin
                  model_stamp[i]  = model_stamp[i-1];
                  model_handle[i] = model_handle[i-1];
               end
               model_stamp[pos]  = word.stamp;
               model_handle[pos] = word.message_handle;
               model_fill++;
            end
         end
         MODE_RESTART: model_cursor = 0;
         MODE_NEXT: begin
            if (model_cursor < model_fill) begin
               result.item_valid = 1'b1;
               result.out_stamp  = model_stamp[model_cursor];
               result.out_handle = model_handle[model_cursor];
               model_cursor++;
            end
         end
         default: ;
      endcase
      result.scan_done   = (model_cursor >= model_fill);
      result.entry_count = COUNT_BITS'(model_fill);
      return result;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 100)
         $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $time);
   endtask

   // Hold the word until taken; wait gap cycles with start low first
   task automatic send_word(input req_type word, input int gap, output rsp_type predicted);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req   <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = list_step(word);
   endtask

   // Drop start and hold off until every result word is back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Random stamp: extremes, a narrow band for ties, a stored stamp, or anything
   function automatic logic [STAMP_BITS-1:0] pick_stamp();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? '1 : '0;
         1: return STAMP_BITS'($urandom_range(0, 7));
         2: return (model_fill > 0) ? model_stamp[$urandom_range(0, model_fill - 1)]
                                    : STAMP_BITS'($urandom);
         default: return STAMP_BITS'($urandom);
      endcase
   endfunction

   // Check each result word against the oldest pending one
   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", rsp, 0);
         end else begin
            want = pending_words.pop_front();
            if (rsp.item_valid !== want.item_valid)
               report_mismatch("item_valid", rsp.item_valid, want.item_valid);
            if (rsp.out_stamp !== want.out_stamp)
               report_mismatch("out_stamp", rsp.out_stamp, want.out_stamp);
            if (rsp.out_handle !== want.out_handle)
               report_mismatch("out_handle", rsp.out_handle, want.out_handle);
            if (rsp.scan_done !== want.scan_done)
               report_mismatch("scan_done", rsp.scan_done, want.scan_done);
            if (rsp.insert_refused !== want.insert_refused)
               report_mismatch("insert_refused", rsp.insert_refused, want.insert_refused);
            if (rsp.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp.entry_count, want.entry_count);
         end
      end
   end

   initial begin : run_stimulus
      req_type word;
      rsp_type predicted;
      int      sent;
      int      gap;
      bit      quiet;
      reset        = 1'b1;
      start        = 1'b0;
      req          = '0;
      error_count  = 0;
      model_fill   = 0;
      model_cursor = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         model_stamp[i]  = '0;
         model_handle[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: typed rows override the model's result word
      for (int r = 0; r < NUM_ROWS; r++) begin
         send_word(plan[r].word, $urandom_range(0, 8), predicted);
         pending_words.push_back(plan[r].typed ? plan[r].want : predicted);
      end
      drain_results();

      // Random words; the list fills early, then scans and refused inserts dominate
      sent  = 0;
      quiet = 1'b0;
      while (sent < WORD_TARGET) begin
         if (sent % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (sent == WORD_TARGET / 2) drain_results();
         word.stamp          = pick_stamp();
         word.message_handle = HANDLE_BITS'($urandom);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:   word.mode = MODE_INSERT;
            6, 7, 8:            word.mode = MODE_RESTART;
            19:                 word.mode = MODE_UNUSED;
            default:            word.mode = MODE_NEXT;
         endcase
         gap = quiet ? 0 : $urandom_range(0, 8);
         send_word(word, gap, predicted);
         pending_words.push_back(predicted);
         if (word.mode != MODE_UNUSED) sent++;
      end

      // Drain, then keep watching for stray words before the verdict
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("timestamp_sorted_insert_list regression: pass");
      else
         $display("timestamp_sorted_insert_list regression: fail");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("timestamp_sorted_insert_list regression: fail");
      $finish;
   end

endmodule
